@@ design/jse_pkg.sv @@
// ----------------------------------------------------------------------------
// jse_pkg
// Types, character codes and escape lookup for the JSON string escaper.
// ----------------------------------------------------------------------------
package jse_pkg;

  localparam int unsigned POS_WIDTH = 16;
  localparam logic [31:0] POS_MAX   = 32'((64'd1 << POS_WIDTH) - 64'd1);

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  localparam logic [15:0] CAP_RESET = 16'hFFFF;
  localparam logic [16:0] POS_ERROR = 17'h1FFFF;

  typedef struct packed {
    logic [2:0]      need;
    logic [5:0][7:0] bytes;
  } esc_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] d);
    logic [7:0] r;
    if (d < 4'd10) r = CH_ZERO + {4'h0, d};
    else           r = CH_A + {4'h0, d} - 8'd10;
    return r;
  endfunction

  function automatic esc_t escape_byte(input logic [7:0] c);
    esc_t e;
    e.need     = 3'd2;
    e.bytes    = '0;
    e.bytes[0] = CH_BSLASH;
    case (c)
      CH_QUOTE:  e.bytes[1] = CH_QUOTE;
      CH_BSLASH: e.bytes[1] = CH_BSLASH;
      CH_LF:     e.bytes[1] = CH_N;
      CH_CR:     e.bytes[1] = CH_R;
      CH_TAB:    e.bytes[1] = CH_T;
      default: begin
        if (c < CTRL_LIMIT) begin
          e.need     = 3'd6;
          e.bytes[1] = CH_U;
          e.bytes[2] = CH_ZERO;
          e.bytes[3] = CH_ZERO;
          e.bytes[4] = hex_digit(c[7:4]);
          e.bytes[5] = hex_digit(c[3:0]);
        end else begin
          e.need     = 3'd1;
          e.bytes[0] = c;
        end
      end
    endcase
    return e;
  endfunction

endpackage

@@ design/json_string_escaper_top.sv @@
// ----------------------------------------------------------------------------
// json_string_escaper_top
// Escapes a raw string byte stream into JSON form with output bounds checking.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one raw byte per item with
//   first/start_pos marking the start of a new string. Output channel
//   (out_valid/out_stall) carries one escaped byte per item, or a single
//   error item (byte_valid 0, overflow 1, position -1) once the string has
//   overflowed out_capacity. last marks the final output item of an input.
//   Each input waits in the escape buffer and its items leave through the
//   output register. Throughput: one output byte per cycle while out_stall
//   is low, set by the single escape buffer; a plain byte gives one byte, a
//   two-byte escape two, a \u00xx escape six. A new input is taken in the
//   same cycle the previous escape sends its last byte. out_capacity is
//   written through cfg_write/cfg_data while idle, which the user, not the
//   block, enforces. Reset (rst, synchronous) empties both stages, sets
//   capacity to 65535, the write position to 0. While out_stall is high the
//   output item holds and the input side stalls once the escape buffer is full.
// ----------------------------------------------------------------------------
module json_string_escaper_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        first,
  input  logic [16:0] start_pos,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        last,
  output logic [16:0] position,
  output logic        overflow
);

  logic [15:0] out_capacity;
  logic        in_error;
  logic [15:0] write_position;

  logic            a_valid;
  logic            a_err;
  logic [2:0]      a_need;
  logic [2:0]      a_idx;
  logic [5:0][7:0] a_bytes;
  logic [15:0]     a_pos;

  logic            accept;
  logic            o_free;
  logic            a_adv;
  logic            a_last;
  logic            eff_err;
  logic [15:0]     eff_pos;
  jse_pkg::esc_t   esc;
  logic [17:0]     sum;
  logic            fits;

  assign o_free = !out_valid || !out_stall;
  assign a_adv  = a_valid && o_free;
  assign a_last = a_err || (a_idx == a_need - 3'd1);
  assign in_stall = a_valid && !(a_adv && a_last);
  assign accept = in_valid && !in_stall;

  always_comb begin
    if (first) begin
      eff_err = start_pos[16] || ({15'h0, start_pos} > jse_pkg::POS_MAX);
      eff_pos = start_pos[15:0];
    end else begin
      eff_err = in_error;
      eff_pos = write_position;
    end
    esc  = jse_pkg::escape_byte(in_byte);
    sum  = {2'b00, eff_pos} + {15'h0, esc.need};
    fits = sum < {2'b00, out_capacity};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= jse_pkg::CAP_RESET;
    end else if (cfg_write) begin
      out_capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_error       <= 1'b0;
      write_position <= '0;
      a_valid        <= 1'b0;
      a_idx          <= '0;
    end else begin
      if (accept) begin
        a_valid <= 1'b1;
        a_idx   <= '0;
        if (eff_err || !fits) begin
          in_error       <= 1'b1;
          write_position <= '0;
        end else begin
          in_error       <= 1'b0;
          write_position <= sum[15:0];
        end
      end else if (a_adv) begin
        if (a_last) a_valid <= 1'b0;
        a_idx <= a_idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_err   <= eff_err || !fits;
      a_need  <= esc.need;
      a_bytes <= esc.bytes;
      a_pos   <= sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_free) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      out_byte   <= a_err ? 8'h00 : a_bytes[a_idx];
      byte_valid <= !a_err;
      last       <= a_last;
      position   <= a_err ? jse_pkg::POS_ERROR : {1'b0, a_pos};
      overflow   <= a_err;
    end
  end

endmodule

@@ design/jse_checker.sv @@
// ----------------------------------------------------------------------------
// jse_checker
// Port-level checks for the JSON string escaper, bound to the top level.
// ----------------------------------------------------------------------------
module jse_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_byte,
  input logic        byte_valid,
  input logic        last,
  input logic [16:0] position,
  input logic        overflow
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last))
    else $error("stalled output item changed");

  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> !byte_valid && last && out_byte == 8'h00 &&
      position == jse_pkg::POS_ERROR)
    else $error("malformed error item");

  a_ok_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_valid |-> !overflow && !position[16])
    else $error("data item flagged as error");

  a_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid)
    else $error("escape sequence broken off");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind json_string_escaper_top jse_checker u_jse_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_byte   (out_byte),
  .byte_valid (byte_valid),
  .last       (last),
  .position   (position),
  .overflow   (overflow)
);

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Randomized check of the JSON string escaper. Raw bytes grouped into
// strings go in through the valid/stall input channel and a scoreboard
// predicts every escaped byte or error item. Each output item is compared
// field by field. The run steps through several buffer capacities and
// idle patterns, and it includes one long output stall.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]  ch;
    logic        first;
    logic [16:0] start;
  } raw_byte_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        valid;
    logic        last;
    logic [16:0] pos;
    logic        ovf;
  } esc_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = '0;
  logic        first = 1'b0;
  logic [16:0] start_pos = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        last;
  logic [16:0] position;
  logic        overflow;

  raw_byte_t   raw_q[$];
  esc_out_t    escaped_q[$];
  logic [15:0] capacity;
  logic        in_error;
  logic [16:0] write_pos;
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          phase_no = -1;
  logic        item_taken = 1'b0;
  logic        hold_off = 1'b0;
  logic [7:0]  esc_chars [5] = '{jse_pkg::CH_QUOTE, jse_pkg::CH_BSLASH, jse_pkg::CH_LF,
                                 jse_pkg::CH_CR, jse_pkg::CH_TAB};

  json_string_escaper_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .first     (first),
    .start_pos (start_pos),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .byte_valid(byte_valid),
    .last      (last),
    .position  (position),
    .overflow  (overflow)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    return (d < 4'd10) ? jse_pkg::CH_ZERO + 8'(d) : jse_pkg::CH_A + 8'(d) - 8'd10;
  endfunction

  task automatic escape_predict(input raw_byte_t it);
    logic [7:0] seq [6];
    int         n;
    esc_out_t   r;
    if (it.first) begin
      in_error  = it.start[16];
      write_pos = it.start[16] ? '0 : it.start;
    end
    r = '{data: '0, valid: 1'b0, last: 1'b1, pos: jse_pkg::POS_ERROR, ovf: 1'b1};
    if (in_error) begin
      escaped_q.push_back(r);
    end else begin
      n = 2;
      for (int i = 0; i < 6; i++) seq[i] = '0;
      seq[0] = jse_pkg::CH_BSLASH;
      case (it.ch)
        jse_pkg::CH_QUOTE:  seq[1] = jse_pkg::CH_QUOTE;
        jse_pkg::CH_BSLASH: seq[1] = jse_pkg::CH_BSLASH;
        jse_pkg::CH_LF:     seq[1] = jse_pkg::CH_N;
        jse_pkg::CH_CR:     seq[1] = jse_pkg::CH_R;
        jse_pkg::CH_TAB:    seq[1] = jse_pkg::CH_T;
        default: begin
          if (it.ch < jse_pkg::CTRL_LIMIT) begin
            n = 6;
            seq[1] = jse_pkg::CH_U;
            seq[2] = jse_pkg::CH_ZERO;
            seq[3] = jse_pkg::CH_ZERO;
            seq[4] = hex_char(it.ch[7:4]);
            seq[5] = hex_char(it.ch[3:0]);
          end else begin
            n = 1;
            seq[0] = it.ch;
          end
        end
      endcase
      if (int'(write_pos) + n >= int'(capacity)) begin
        in_error  = 1'b1;
        write_pos = '0;
        escaped_q.push_back(r);
      end else begin
        write_pos = write_pos + 17'(n);
        for (int i = 0; i < n; i++) begin
          r.data  = seq[i];
          r.valid = 1'b1;
          r.last  = (i == n - 1);
          r.pos   = write_pos;
          r.ovf   = 1'b0;
          escaped_q.push_back(r);
        end
      end
    end
  endtask

  task automatic note_mismatch(input string what, input esc_out_t want, input esc_out_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"%0t %s: expected byte %h valid %b last %b pos %h ovf %b, ",
                "got byte %h valid %b last %b pos %h ovf %b"},
               $realtime, what, want.data, want.valid, want.last, want.pos, want.ovf,
               got.data, got.valid, got.last, got.pos, got.ovf);
  endtask

  always @(posedge clk) begin : monitor
    esc_out_t got;
    esc_out_t want;
    if (rst) begin
      item_taken = 1'b0;
    end else begin
      item_taken = in_valid && !in_stall;
      if (item_taken) escape_predict(raw_byte_t'{in_byte, first, start_pos});
      if (out_valid && !out_stall) begin
        got = '{out_byte, byte_valid, last, position, overflow};
        if (escaped_q.size() == 0) begin
          note_mismatch("unexpected item", '0, got);
        end else begin
          want = escaped_q.pop_front();
          if (got != want) note_mismatch("wrong item", want, got);
        end
      end
    end
  end

  always @(negedge clk) begin : driver
    raw_byte_t it;
    if (!rst) begin
      if (!in_valid || item_taken) begin
        if (raw_q.size() != 0 && int'($urandom_range(99, 0)) >= send_idle_pct) begin
          it = raw_q.pop_front();
          in_valid  <= 1'b1;
          in_byte   <= it.ch;
          first     <= it.first;
          start_pos <= it.start;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= hold_off || (int'($urandom_range(99, 0)) < recv_idle_pct);
    end
  end

  // hold the output back long enough to back up the input side
  initial begin : hold_proc
    wait (phase_no == 4);
    repeat (4) @(posedge clk);
    hold_off = 1'b1;
    repeat (80) @(posedge clk);
    hold_off = 1'b0;
  end

  task automatic send(input logic [7:0] ch, input logic f, input logic [16:0] sp);
    raw_q.push_back('{ch, f, sp});
  endtask

  task automatic gen_strings(input int n);
    int        made;
    int        len;
    int        sel;
    int        sp;
    raw_byte_t it;
    made = 0;
    while (made < n) begin
      sel = $urandom_range(99, 0);
      if (sel < 55) begin
        sp = $urandom_range(16, 0);
      end else if (sel < 75) begin
        sp = int'(capacity) - int'($urandom_range(30, 0));
        if (sp < 0) sp = 0;
      end else if (sel < 88) begin
        sp = $urandom_range(17'h1FFFF, 0);
      end else begin
        sp = -1;
      end
      len = $urandom_range(12, 1);
      for (int i = 0; i < len; i++) begin
        sel = $urandom_range(99, 0);
        if (sel < 30)      it.ch = esc_chars[3'($urandom_range(4, 0))];
        else if (sel < 50) it.ch = 8'($urandom_range(31, 0));
        else               it.ch = 8'($urandom_range(255, 0));
        it.first = (i == 0);
        it.start = (i == 0) ? 17'(sp) : 17'($urandom_range(17'h1FFFF, 0));
        raw_q.push_back(it);
        made++;
      end
    end
  endtask

  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (raw_q.size() != 0 || in_valid || escaped_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [15:0] caps [6];
    capacity  = jse_pkg::CAP_RESET;
    in_error  = 1'b0;
    write_pos = '0;
    caps = '{jse_pkg::CAP_RESET, 16'd20, 16'd1, 16'd0, jse_pkg::CAP_RESET,
             16'($urandom_range(65535, 2))};
    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    @(posedge clk);
    for (int p = 0; p < 6; p++) begin
      if (p != 0) begin
        wait_idle();
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= caps[p];
        capacity   = caps[p];
        @(negedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
      end
      phase_no      = p;
      send_idle_pct = (p / 2 == 0) ? 26 : (p / 2 == 1) ? 71 : 0;
      recv_idle_pct = (p / 2 == 0) ? 71 : (p / 2 == 1) ? 26 : 0;
      if (p == 0) begin
        // continue from offset zero without a string start
        send(8'h41, 1'b0, 17'h00000);
        send(jse_pkg::CH_QUOTE, 1'b0, 17'h1FFFF);
        send(jse_pkg::CH_BSLASH, 1'b0, 17'h00000);
        send(jse_pkg::CH_LF, 1'b0, 17'h0FFFF);
        send(jse_pkg::CH_CR, 1'b0, 17'h10000);
        send(jse_pkg::CH_TAB, 1'b0, 17'h00000);
        send(8'h00, 1'b0, 17'h00000);
        send(8'h1F, 1'b0, 17'h00000);
        send(8'h20, 1'b0, 17'h00000);
        send(8'hFF, 1'b0, 17'h00000);
        send(8'h7F, 1'b0, 17'h00000);
        send(8'h80, 1'b0, 17'h00000);
        // strings that start in error
        send(8'h78, 1'b1, 17'h1FFFF);
        send(8'h79, 1'b0, 17'h00000);
        send(8'h00, 1'b1, 17'h10000);
        // overflow near the top of the buffer
        send(8'h61, 1'b1, 17'h0FFFF);
        send(8'h62, 1'b1, 17'h0FFFD);
        send(8'h63, 1'b0, 17'h00000);
        send(8'h64, 1'b0, 17'h00000);
        send(8'h01, 1'b1, 17'h0FFF8);
        send(8'h01, 1'b1, 17'h0FFF9);
        send(jse_pkg::CH_QUOTE, 1'b1, 17'h00000);
        send(jse_pkg::CH_BSLASH, 1'b1, 17'h0FFFC);
      end
      gen_strings(38);
    end
    wait_idle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ json_string_escaper_top.f @@
design/jse_pkg.sv
design/json_string_escaper_top.sv
design/jse_checker.sv
bench/tb.sv
